>>> hw/rtl/lirs_pkg.sv
// Shared types and constants of the linear interpolation resampler.
// Used by the front, sequencer, interpolation and top-level modules; depends on nothing.
`default_nettype none

package lirs_pkg;

	localparam int OUT_RATE    = 48000;
	localparam int SAMPLE_BITS = 16;
	localparam int RATE_W      = 17;
	localparam int RATE_MIN    = 8000;
	localparam int RATE_MAX    = 96000;
	localparam int RATE_RESET  = 48000;
	localparam int PH_W        = 16;
	localparam int FRAC_W      = 16;
	localparam int PH_SUM_W    = 18;

	// frac = floor(ph * 65536 / OUT_RATE) = floor(ph * FRAC_RECIP >> FRAC_SHIFT), exact for ph < OUT_RATE
	localparam int RECIP_W            = 25;
	localparam logic [RECIP_W-1:0] FRAC_RECIP = 25'd22906493;
	localparam int FRAC_SHIFT         = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 2'd1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    fin;
	} item_t;

	typedef struct packed {
		logic              valid;
		sample_t           a_l;
		sample_t           a_r;
		sample_t           b_l;
		sample_t           b_r;
		logic [PH_W-1:0]   ph;
		logic              run_end;
		logic              stream_end;
	} op_t;

endpackage

`default_nettype wire

>>> hw/rtl/lirs_front.sv
// Front end: accepts source frames, applies mono duplication, queues them.
// Depends on lirs_pkg.
`default_nettype none

module lirs_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [31:0]           s_tdata,  // src_left [15:0], src_right [31:16]
	input  wire logic                  s_tlast,  // final_frame
	input  wire logic                  stereo,
	output lirs_pkg::item_t            item,
	output logic                       item_valid,
	input  wire logic                  item_pop
);

	lirs_pkg::item_t               q_mem_q [lirs_pkg::QUEUE_DEPTH];
	logic [lirs_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [lirs_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [lirs_pkg::QPTR_W:0]     count_q;
	lirs_pkg::item_t               in_item;
	logic                          push;
	logic                          pop;

	assign s_tready   = (count_q != (lirs_pkg::QPTR_W + 1)'(lirs_pkg::QUEUE_DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = q_mem_q[rd_ptr_q];
	assign push       = s_tvalid & s_tready;
	assign pop        = item_pop & item_valid;

	always_comb begin
		in_item.left  = s_tdata[15:0];
		in_item.right = stereo ? s_tdata[31:16] : s_tdata[15:0];
		in_item.fin   = s_tlast;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/lirs_seq.sv
// Back-end sequencer: walks output positions through each source interval,
// keeps phase and history state, and issues interpolation ops.
// Depends on lirs_pkg.
`default_nettype none

module lirs_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lirs_pkg::item_t               item,
	input  wire logic                          item_valid,
	output logic                               item_pop,
	input  wire logic [lirs_pkg::RATE_W-1:0]   source_rate,
	input  wire logic                          adv,
	output lirs_pkg::op_t                      op
);

	typedef enum logic [2:0] {
		SEQ_IDLE  = 3'b001,
		SEQ_RUN_A = 3'b010,
		SEQ_RUN_B = 3'b100
	} seq_state_t;

	seq_state_t                       state_q;
	lirs_pkg::sample_t                prev_l_q;
	lirs_pkg::sample_t                prev_r_q;
	logic                             have_prev_q;
	logic [lirs_pkg::PH_W-1:0]        ph_q;
	logic [1:0]                       fts_q;
	lirs_pkg::item_t                  cur_q;

	logic [lirs_pkg::PH_SUM_W-1:0]    ph_sum;
	logic [lirs_pkg::PH_W-1:0]        ph_n;
	logic [1:0]                       fts_n;
	logic                             emit;
	logic                             last;

	always_comb begin
		ph_sum = {2'b00, ph_q} + {1'b0, source_rate};
		if (ph_sum >= lirs_pkg::PH_SUM_W'(2 * lirs_pkg::OUT_RATE)) begin
			ph_n  = lirs_pkg::PH_W'(ph_sum - lirs_pkg::PH_SUM_W'(2 * lirs_pkg::OUT_RATE));
			fts_n = 2'd2;
		end else if (ph_sum >= lirs_pkg::PH_SUM_W'(lirs_pkg::OUT_RATE)) begin
			ph_n  = lirs_pkg::PH_W'(ph_sum - lirs_pkg::PH_SUM_W'(lirs_pkg::OUT_RATE));
			fts_n = 2'd1;
		end else begin
			ph_n  = ph_sum[lirs_pkg::PH_W-1:0];
			fts_n = 2'd0;
		end
	end

	always_comb begin
		emit = (state_q != SEQ_IDLE) && (fts_q == 2'd0);
		last = (fts_n != 2'd0) && ((state_q == SEQ_RUN_B) || !cur_q.fin || (fts_n == 2'd2));
		op            = '0;
		op.valid      = emit;
		op.ph         = ph_q;
		op.run_end    = emit & last;
		op.stream_end = emit & last & cur_q.fin;
		op.b_l        = cur_q.left;
		op.b_r        = cur_q.right;
		if (state_q == SEQ_RUN_A) begin
			op.a_l = prev_l_q;
			op.a_r = prev_r_q;
		end else begin
			op.a_l = cur_q.left;
			op.a_r = cur_q.right;
		end
	end

	assign item_pop = (state_q == SEQ_IDLE) && item_valid;

	always_ff @(posedge clk) begin
		if (item_pop) begin
			cur_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			have_prev_q <= 1'b0;
			ph_q        <= '0;
			fts_q       <= '0;
		end else begin
			case (state_q)
				SEQ_IDLE: begin
					if (item_valid) begin
						if (have_prev_q) begin
							state_q <= SEQ_RUN_A;
						end else if (item.fin) begin
							state_q <= SEQ_RUN_B;
						end else begin
							prev_l_q    <= item.left;
							prev_r_q    <= item.right;
							have_prev_q <= 1'b1;
						end
					end
				end
				SEQ_RUN_A: begin
					if (adv) begin
						if (fts_q == 2'd0) begin
							ph_q  <= ph_n;
							fts_q <= fts_n;
						end else begin
							fts_q       <= fts_q - 2'd1;
							prev_l_q    <= cur_q.left;
							prev_r_q    <= cur_q.right;
							have_prev_q <= 1'b1;
							state_q     <= cur_q.fin ? SEQ_RUN_B : SEQ_IDLE;
						end
					end
				end
				SEQ_RUN_B: begin
					if (adv) begin
						if (fts_q == 2'd0) begin
							ph_q  <= ph_n;
							fts_q <= fts_n;
						end else begin
							prev_l_q    <= '0;
							prev_r_q    <= '0;
							have_prev_q <= 1'b0;
							ph_q        <= '0;
							fts_q       <= '0;
							state_q     <= SEQ_IDLE;
						end
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/lirs_interp.sv
// Back-end datapath: fraction, interpolation and downmix pipeline with the
// output register of the result stream. Depends on lirs_pkg.
`default_nettype none

module lirs_interp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lirs_pkg::op_t  op,
	output logic                adv,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [47:0]         m_tdata,  // out_left [15:0], out_right [31:16], out_mono [47:32]
	output logic                m_tlast,  // run_end
	output logic                m_tuser   // stream_end
);

	localparam int PROD_W = lirs_pkg::PH_W + lirs_pkg::RECIP_W;
	localparam int DIFF_W = lirs_pkg::SAMPLE_BITS + 1;
	localparam int MUL_W  = 2 * DIFF_W;

	lirs_pkg::op_t                    op_s1;
	logic                             v_s1;

	logic                             v_s2;
	logic [lirs_pkg::FRAC_W-1:0]      frac_s2;
	logic signed [DIFF_W-1:0]         dl_s2;
	logic signed [DIFF_W-1:0]         dr_s2;
	lirs_pkg::sample_t                al_s2;
	lirs_pkg::sample_t                ar_s2;
	logic [1:0]                       flags_s2;

	logic                             v_s3;
	logic signed [MUL_W-1:0]          pl_s3;
	logic signed [MUL_W-1:0]          pr_s3;
	lirs_pkg::sample_t                al_s3;
	lirs_pkg::sample_t                ar_s3;
	logic [1:0]                       flags_s3;

	logic                             out_valid_q;
	lirs_pkg::sample_t                out_l_q;
	lirs_pkg::sample_t                out_r_q;
	lirs_pkg::sample_t                out_m_q;
	logic [1:0]                       out_flags_q;

	logic [PROD_W-1:0]                fprod;
	logic signed [MUL_W-lirs_pkg::FRAC_W-1:0] ql;
	logic signed [MUL_W-lirs_pkg::FRAC_W-1:0] qr;
	logic signed [MUL_W-lirs_pkg::FRAC_W-1:0] lf;
	logic signed [MUL_W-lirs_pkg::FRAC_W-1:0] rf;
	lirs_pkg::sample_t                l_n;
	lirs_pkg::sample_t                r_n;
	logic signed [DIFF_W-1:0]         msum;

	assign adv = !out_valid_q || m_tready;

	always_comb begin
		fprod = PROD_W'(op_s1.ph) * PROD_W'(lirs_pkg::FRAC_RECIP);
		ql    = pl_s3[MUL_W-1:lirs_pkg::FRAC_W];
		qr    = pr_s3[MUL_W-1:lirs_pkg::FRAC_W];
		lf    = ql + (MUL_W - lirs_pkg::FRAC_W)'(al_s3);
		rf    = qr + (MUL_W - lirs_pkg::FRAC_W)'(ar_s3);
		l_n   = lf[lirs_pkg::SAMPLE_BITS-1:0];
		r_n   = rf[lirs_pkg::SAMPLE_BITS-1:0];
		msum  = DIFF_W'(l_n) + DIFF_W'(r_n);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= op;

			frac_s2  <= fprod[lirs_pkg::FRAC_SHIFT+lirs_pkg::FRAC_W-1:lirs_pkg::FRAC_SHIFT];
			dl_s2    <= DIFF_W'(op_s1.b_l) - DIFF_W'(op_s1.a_l);
			dr_s2    <= DIFF_W'(op_s1.b_r) - DIFF_W'(op_s1.a_r);
			al_s2    <= op_s1.a_l;
			ar_s2    <= op_s1.a_r;
			flags_s2 <= {op_s1.stream_end, op_s1.run_end};

			pl_s3    <= dl_s2 * $signed({1'b0, frac_s2});
			pr_s3    <= dr_s2 * $signed({1'b0, frac_s2});
			al_s3    <= al_s2;
			ar_s3    <= ar_s2;
			flags_s3 <= flags_s2;

			out_l_q     <= l_n;
			out_r_q     <= r_n;
			out_m_q     <= msum[DIFF_W-1:1];
			out_flags_q <= flags_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= op.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_m_q, out_r_q, out_l_q};
	assign m_tlast  = out_flags_q[0];
	assign m_tuser  = out_flags_q[1];

endmodule

`default_nettype wire

>>> hw/rtl/linear_interp_resampler_core.sv
// Top level of the linear interpolation resampler: configuration registers
// and the front queue, sequencer and interpolation pipeline.
// Depends on lirs_pkg, lirs_front, lirs_seq and lirs_interp.
//
// Source frames enter a four-frame queue and are resampled to 48 kHz output
// frames. The sequencer picks a frame from the queue, then issues one output
// frame per cycle while the output is not stalled and closes each source
// interval in a further step; a final frame also closes a trailing interval.
// Each output frame leaves a four-stage interpolation pipeline; a stalled
// output stalls the sequencer while the queue keeps taking frames until it
// is full. Writes to source_rate saturate to 8000..96000 Hz. Configure only
// while the block is idle.
`default_nettype none

module linear_interp_resampler_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lirs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lirs_pkg::RATE_W-1:0]      cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [31:0]                      s_tdata,  // src_left [15:0], src_right [31:16]
	input  wire logic                             s_tlast,  // final_frame
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [47:0]                           m_tdata,  // out_left, out_right, out_mono
	output logic                                  m_tlast,  // run_end
	output logic                                  m_tuser   // stream_end
);

	logic [lirs_pkg::RATE_W-1:0]  source_rate_q;
	logic                         stereo_q;
	logic [lirs_pkg::RATE_W-1:0]  rate_sat;
	lirs_pkg::item_t              item;
	logic                         item_valid;
	logic                         item_pop;
	lirs_pkg::op_t                op;
	logic                         adv;

	always_comb begin
		if (cfg_wdata < lirs_pkg::RATE_W'(lirs_pkg::RATE_MIN)) begin
			rate_sat = lirs_pkg::RATE_W'(lirs_pkg::RATE_MIN);
		end else if (cfg_wdata > lirs_pkg::RATE_W'(lirs_pkg::RATE_MAX)) begin
			rate_sat = lirs_pkg::RATE_W'(lirs_pkg::RATE_MAX);
		end else begin
			rate_sat = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_rate_q <= lirs_pkg::RATE_W'(lirs_pkg::RATE_RESET);
			stereo_q      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				lirs_pkg::CFG_SOURCE_RATE: source_rate_q <= rate_sat;
				lirs_pkg::CFG_STEREO:      stereo_q      <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	lirs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.stereo     (stereo_q),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	lirs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_pop    (item_pop),
		.source_rate (source_rate_q),
		.adv         (adv),
		.op          (op)
	);

	lirs_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

>>> hw/rtl/lirs_checker.sv
// Port-level checks of the resampler result stream, bound to the top level.
// Depends on linear_interp_resampler_core.
`default_nettype none

module lirs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        m_tuser
);

	logic signed [16:0] mono_sum;

	assign mono_sum = {m_tdata[15], m_tdata[15:0]} + {m_tdata[31], m_tdata[31:16]};

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_stream_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("stream end without run end");

	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:32] == mono_sum[16:1])
		else $error("downmix does not match left and right");

endmodule

bind linear_interp_resampler_core lirs_checker u_lirs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire

>>> test/linear_interp_resampler_core_test.sv
// Self-checking bench for linear_interp_resampler_core: drives source frames and
// register writes, predicts every 48 kHz output frame and checks the output stream.
// Depends on lirs_pkg and the resampler RTL.
`timescale 1ns / 100ps

module linear_interp_resampler_core_test;
	import lirs_pkg::*;

	localparam int MAX_RESULTS = 12;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		sample_t left;
		sample_t right;
		sample_t mono;
		logic    run_end;
		logic    stream_end;
	} out_frame_t;

	class resample_scoreboard;
		int unsigned rate;
		bit          stereo;
		longint      prev_l;
		longint      prev_r;
		bit          have_prev;
		int unsigned phase;
		int unsigned skip;
		out_frame_t  step_out[$];
		out_frame_t  due_frames[$];
		int          errors;

		function new();
			rate = RATE_RESET;
			stereo = 1'b1;
			errors = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			prev_l = 0;
			prev_r = 0;
			have_prev = 1'b0;
			phase = 0;
			skip = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
			int unsigned v;
			v = val;
			if (idx == CFG_SOURCE_RATE) begin
				if (v < RATE_MIN)
					v = RATE_MIN;
				if (v > RATE_MAX)
					v = RATE_MAX;
				rate = v;
			end else if (idx == CFG_STEREO) begin
				stereo = val[0];
			end
		endfunction

		function void advance_phase();
			phase += rate;
			while (phase >= OUT_RATE) begin
				phase -= OUT_RATE;
				skip++;
			end
		endfunction

		// emit every output position inside the interval a..b, then consume it
		function void sweep_interval(longint al, longint ar, longint bl, longint br);
			longint     frac;
			longint     l;
			longint     r;
			out_frame_t f;
			while (skip == 0) begin
				if (step_out.size() < MAX_RESULTS) begin
					frac = (longint'(phase) << 16) / OUT_RATE;
					l = al + (((bl - al) * frac) >>> 16);
					r = ar + (((br - ar) * frac) >>> 16);
					f.left = sample_t'(l);
					f.right = sample_t'(r);
					f.mono = sample_t'((l + r) >>> 1);
					f.run_end = 1'b0;
					f.stream_end = 1'b0;
					step_out.insert(step_out.size(), f);
				end
				advance_phase();
			end
			skip--;
		endfunction

		function void take_source_frame(sample_t l, sample_t r, bit fin);
			longint     xl;
			longint     xr;
			out_frame_t f;
			xl = l;
			xr = stereo ? longint'(r) : xl;
			step_out.delete();
			if (have_prev)
				sweep_interval(prev_l, prev_r, xl, xr);
			prev_l = xl;
			prev_r = xr;
			have_prev = 1'b1;
			if (fin) begin
				sweep_interval(xl, xr, xl, xr);
				clear_stream();
			end
			if (step_out.size() > 0) begin
				f = step_out.pop_back();
				f.run_end = 1'b1;
				f.stream_end = fin;
				step_out.insert(step_out.size(), f);
			end
			foreach (step_out[i])
				due_frames.insert(due_frames.size(), step_out[i]);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_output_frame(out_frame_t got);
			out_frame_t want;
			if (due_frames.size() == 0) begin
				report($sformatf("output frame with none pending: %h", got));
			end else begin
				want = due_frames.pop_front();
				if (got.left !== want.left)
					report($sformatf("out_left %0d, want %0d", got.left, want.left));
				if (got.right !== want.right)
					report($sformatf("out_right %0d, want %0d", got.right, want.right));
				if (got.mono !== want.mono)
					report($sformatf("out_mono %0d, want %0d", got.mono, want.mono));
				if (got.run_end !== want.run_end)
					report($sformatf("run_end %b, want %b", got.run_end, want.run_end));
				if (got.stream_end !== want.stream_end)
					report($sformatf("stream_end %b, want %b",
						got.stream_end, want.stream_end));
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATE_W-1:0]    cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [47:0]          m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;

	resample_scoreboard sb;
	int unsigned        src_idle_pct;
	int unsigned        rcv_stall_pct;
	int unsigned        cycles;

	linear_interp_resampler_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_output_frame({m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
				m_tlast, m_tuser});
		m_tready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	task automatic send_frame(input sample_t l, input sample_t r, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r, l};
		s_tlast <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		sb.take_source_frame(l, r, fin);
	endtask

	// drain all pending output, then let the sequencer finish any frame in flight
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (sb.due_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic random_frames(input int count);
		sample_t l;
		sample_t r;
		for (int i = 0; i < count; i++) begin
			l = pick_sample();
			r = pick_sample();
			send_frame(l, r, $urandom_range(7) == 0);
		end
	endtask

	initial begin
		int unsigned seg_rate;
		sb = new();
		cycles <= 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SOURCE_RATE;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		src_idle_pct = 0;
		rcv_stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 48 kHz stereo, full-scale swings and a single-frame stream
		send_frame(16'h7FFF, 16'h8000, 1'b0);
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		send_frame(16'h0000, 16'hFFFF, 1'b1);
		send_frame(16'hFFFF, 16'h0001, 1'b1);
		settle_idle();

		// rate below range saturates to the slowest source, mono copies left
		write_reg(CFG_SOURCE_RATE, 17'd0);
		write_reg(CFG_STEREO, 17'd0);
		send_frame(16'h7FFF, 16'h0005, 1'b0);
		send_frame(16'h8000, 16'hFFFB, 1'b1);
		settle_idle();

		// rate above range saturates to the fastest source
		write_reg(CFG_SOURCE_RATE, 17'h1FFFF);
		write_reg(CFG_STEREO, 17'd1);
		send_frame(16'h8000, 16'h8000, 1'b0);
		send_frame(16'h7FFF, 16'h7FFF, 1'b0);
		send_frame(16'h0001, 16'hFFFF, 1'b0);
		send_frame(16'hFFFF, 16'h0001, 1'b1);
		settle_idle();

		// change rate in the middle of a stream, spare indexes are ignored
		write_reg(CFG_SOURCE_RATE, 17'd44100);
		send_frame(16'h0064, 16'h00C8, 1'b0);
		send_frame(16'h012C, 16'hFE70, 1'b0);
		settle_idle();
		write_reg(CFG_SOURCE_RATE, 17'd7999);
		write_reg(CFG_SPARE_A, 17'h1FFFF);
		write_reg(CFG_SPARE_B, 17'd0);
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		send_frame(16'h7FFF, 16'h8000, 1'b1);
		settle_idle();
		write_reg(CFG_SOURCE_RATE, 17'd96001);
		send_frame(16'h1234, 16'h5678, 1'b0);
		send_frame(16'hEDCB, 16'hA987, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin src_idle_pct = 45; rcv_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  rcv_stall_pct = 45; end
				default: begin src_idle_pct = 8; rcv_stall_pct = 8; end
			endcase
			for (int seg = 0; seg < 2; seg++) begin
				settle_idle();
				case (ph * 2 + seg)
					0: seg_rate = RATE_MIN;
					1: seg_rate = RATE_MAX;
					2: seg_rate = $urandom_range(0, 131071);
					default: seg_rate = $urandom_range(RATE_MIN, RATE_MAX);
				endcase
				write_reg(CFG_SOURCE_RATE, seg_rate[RATE_W-1:0]);
				write_reg(CFG_STEREO, RATE_W'(((ph * 2 + seg) % 3) != 1));
				random_frames(40);
			end
		end

		settle_idle();
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/lirs_pkg.sv
hw/rtl/lirs_front.sv
hw/rtl/lirs_seq.sv
hw/rtl/lirs_interp.sv
hw/rtl/linear_interp_resampler_core.sv
hw/rtl/lirs_checker.sv
test/linear_interp_resampler_core_test.sv
